/* hdl/spbr_pkg.sv */
// Shared types and constants for the sync pulse byte receiver.
`timescale 1ns / 1ps

package spbr_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned TickWidth     = 12;
  localparam int unsigned SearchWidth   = 16;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned BitIndexWidth = 3;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_SYNC_TICKS      = 2'd0,
    CFG_SYNC_MARGIN     = 2'd1,
    CFG_BIT_TICKS       = 2'd2,
    CFG_TIMEOUT_SAMPLES = 2'd3
  } cfg_index_t;

  localparam logic [TickWidth-1:0]   SYNC_TICKS_RESET      = 12'd150;
  localparam logic [TickWidth-1:0]   SYNC_MARGIN_RESET     = 12'd20;
  localparam logic [TickWidth-1:0]   BIT_TICKS_RESET       = 12'd100;
  localparam logic [SearchWidth-1:0] TIMEOUT_SAMPLES_RESET = 16'd8000;

  localparam logic [TickWidth-1:0]     PULSE_MAX = '1;
  localparam logic [BitIndexWidth-1:0] LAST_BIT  = '1;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [TickWidth-1:0]   sync_ticks;
    logic [TickWidth-1:0]   sync_margin;
    logic [TickWidth-1:0]   bit_ticks;
    logic [SearchWidth-1:0] timeout_samples;
  } cfg_t;

  typedef struct packed {
    logic                 emit;
    logic                 kind;
    logic [ByteWidth-1:0] data;
  } result_t;

endpackage

/* hdl/spbr_cfg_regs.sv */
// Configuration register bank for the sync pulse byte receiver.
`timescale 1ns / 1ps

module spbr_cfg_regs
  import spbr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_ticks      <= SYNC_TICKS_RESET;
      cfg.sync_margin     <= SYNC_MARGIN_RESET;
      cfg.bit_ticks       <= BIT_TICKS_RESET;
      cfg.timeout_samples <= TIMEOUT_SAMPLES_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SYNC_TICKS:      cfg.sync_ticks      <= cfg_data[TickWidth-1:0];
        CFG_SYNC_MARGIN:     cfg.sync_margin     <= cfg_data[TickWidth-1:0];
        CFG_BIT_TICKS:       cfg.bit_ticks       <= cfg_data[TickWidth-1:0];
        CFG_TIMEOUT_SAMPLES: cfg.timeout_samples <= cfg_data[SearchWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hdl/spbr_core.sv */
// Sync search and data bit sampling state, advanced once per line sample.
`timescale 1ns / 1ps

module spbr_core
  import spbr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  logic    level,
  input  cfg_t    cfg,
  output result_t res
);

  logic                     receiving, receiving_next;
  logic                     prev_level, prev_level_next;
  logic                     prev_valid, prev_valid_next;
  logic                     rise_seen, rise_seen_next;
  logic [TickWidth-1:0]     pulse_count, pulse_count_next;
  logic [SearchWidth-1:0]   search_count, search_count_next;
  logic [TickWidth-1:0]     bit_timer, bit_timer_next;
  logic [BitIndexWidth-1:0] bit_index, bit_index_next;
  logic [ByteWidth-1:0]     shift_bits, shift_bits_next;

  logic                   rising, falling;
  logic [TickWidth:0]     timer_inc;
  logic [TickWidth:0]     diff;
  logic [TickWidth-1:0]   abs_diff;
  logic [SearchWidth-1:0] search_inc;
  logic [ByteWidth-1:0]   shifted;

  always_comb begin
    receiving_next    = receiving;
    prev_level_next   = prev_level;
    prev_valid_next   = prev_valid;
    rise_seen_next    = rise_seen;
    pulse_count_next  = pulse_count;
    search_count_next = search_count;
    bit_timer_next    = bit_timer;
    bit_index_next    = bit_index;
    shift_bits_next   = shift_bits;
    res               = '0;

    rising     = prev_valid && !prev_level && level;
    falling    = prev_valid && prev_level && !level;
    timer_inc  = {1'b0, bit_timer} + 1'b1;
    shifted    = {shift_bits[ByteWidth-2:0], level};
    search_inc = search_count + 1'b1;
    diff       = '0;
    abs_diff   = '0;

    if (receiving) begin
      // A bit period of zero compares true on every tick, same as one.
      if (timer_inc >= {1'b0, cfg.bit_ticks}) begin
        bit_timer_next  = '0;
        shift_bits_next = shifted;
        if (bit_index == LAST_BIT) begin
          res.emit          = 1'b1;
          res.kind          = KIND_DATA;
          res.data          = shifted;
          receiving_next    = 1'b0;
          prev_level_next   = 1'b0;
          prev_valid_next   = 1'b0;
          rise_seen_next    = 1'b0;
          pulse_count_next  = '0;
          search_count_next = '0;
          bit_index_next    = '0;
          shift_bits_next   = '0;
        end else begin
          bit_index_next = bit_index + 1'b1;
        end
      end else begin
        bit_timer_next = timer_inc[TickWidth-1:0];
      end
    end else begin
      if (rising) begin
        rise_seen_next   = 1'b1;
        pulse_count_next = '0;
      end else if (pulse_count != PULSE_MAX) begin
        pulse_count_next = pulse_count + 1'b1;
      end
      prev_level_next = level;
      prev_valid_next = 1'b1;

      diff     = {1'b0, pulse_count_next} - {1'b0, cfg.sync_ticks};
      abs_diff = diff[TickWidth] ? TickWidth'(-diff) : diff[TickWidth-1:0];

      if (falling && rise_seen && (abs_diff < cfg.sync_margin)) begin
        // Sync found: this sample is not counted against the search.
        receiving_next  = 1'b1;
        bit_timer_next  = '0;
        bit_index_next  = '0;
        shift_bits_next = '0;
      end else begin
        search_count_next = search_inc;
        if (search_inc >= cfg.timeout_samples) begin
          res.emit          = 1'b1;
          res.kind          = KIND_TIMEOUT;
          res.data          = '0;
          prev_level_next   = 1'b0;
          prev_valid_next   = 1'b0;
          rise_seen_next    = 1'b0;
          pulse_count_next  = '0;
          search_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving    <= 1'b0;
      prev_level   <= 1'b0;
      prev_valid   <= 1'b0;
      rise_seen    <= 1'b0;
      pulse_count  <= '0;
      search_count <= '0;
      bit_timer    <= '0;
      bit_index    <= '0;
      shift_bits   <= '0;
    end else if (fire) begin
      receiving    <= receiving_next;
      prev_level   <= prev_level_next;
      prev_valid   <= prev_valid_next;
      rise_seen    <= rise_seen_next;
      pulse_count  <= pulse_count_next;
      search_count <= search_count_next;
      bit_timer    <= bit_timer_next;
      bit_index    <= bit_index_next;
      shift_bits   <= shift_bits_next;
    end
  end

endmodule

/* hdl/sync_pulse_byte_receiver_top.sv */
// Top level of the sync pulse byte receiver: sample register, core and result register.
`timescale 1ns / 1ps

// One line sample is taken per cycle while the result side does not stall. A sample is
// captured in the input register; the core advances its search or bit sampling state
// from it when the result side is ready, and any result (a data byte or a search
// timeout) is written to the output register in that same cycle. A stalled result
// holds the core, and the input register then holds one more sample before
// sample_stall rises. Configuration registers are written with cfg_write and take
// effect for the next sample processed.
module sync_pulse_byte_receiver_top
  import spbr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  logic                     line_level,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     result_kind,
  output logic [ByteWidth-1:0]     data_byte,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  cfg_t    cfg;
  result_t res;

  logic sample_full;
  logic sample_level;
  logic out_ready;
  logic fire;
  logic accept;

  assign out_ready    = !result_valid || !result_stall;
  assign fire         = sample_full && out_ready;
  assign sample_stall = sample_full && !out_ready;
  assign accept       = sample_valid && !sample_stall;

  spbr_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spbr_core u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .level (sample_level),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_full <= 1'b0;
    end else if (accept) begin
      sample_full <= 1'b1;
    end else if (fire) begin
      sample_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_level <= line_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= fire && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      result_kind <= res.kind;
      data_byte   <= res.data;
    end
  end

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the sync pulse byte receiver top level.
`timescale 1ns / 1ps

module tb
  import spbr_pkg::*;
();

  typedef struct packed {
    logic                 kind;
    logic [ByteWidth-1:0] data;
  } rx_result_t;

  logic clk = 1'b0;
  logic rst;
  logic sample_valid;
  logic sample_stall;
  logic line_level;
  logic result_valid;
  logic result_stall = 1'b0;
  logic result_kind;
  logic [ByteWidth-1:0] data_byte;
  logic cfg_write;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  // Receiver model state and its copy of the registers.
  cfg_t rx_cfg;
  logic rx_receiving;
  logic rx_prev_level;
  logic rx_prev_valid;
  logic rx_rise_seen;
  logic [TickWidth-1:0] rx_pulse_count;
  logic [SearchWidth-1:0] rx_search_count;
  logic [TickWidth-1:0] rx_bit_timer;
  logic [BitIndexWidth-1:0] rx_bit_index;
  logic [ByteWidth-1:0] rx_shift_bits;

  rx_result_t rx_expected_q[$];
  rx_result_t head_r;
  int fail_count = 0;
  int sample_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  sync_pulse_byte_receiver_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .line_level   (line_level),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_kind  (result_kind),
    .data_byte    (data_byte),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Outputs are stable from the falling edge to the rising edge that accepts them.
  always @(negedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (rx_expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d data %02h",
                 $time, result_kind, data_byte);
        fail_count++;
      end else begin
        head_r = rx_expected_q.pop_front();
        if (result_kind !== head_r.kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time, head_r.kind,
                   result_kind);
          fail_count++;
        end
        if (data_byte !== head_r.data) begin
          $display("%0t: data_byte expected %02h actual %02h", $time, head_r.data,
                   data_byte);
          fail_count++;
        end
      end
    end
  end

  task automatic start_fresh_search();
    rx_receiving = 1'b0;
    rx_prev_level = 1'b0;
    rx_prev_valid = 1'b0;
    rx_rise_seen = 1'b0;
    rx_pulse_count = '0;
    rx_search_count = '0;
  endtask

  task automatic reset_receiver_model();
    rx_cfg.sync_ticks = SYNC_TICKS_RESET;
    rx_cfg.sync_margin = SYNC_MARGIN_RESET;
    rx_cfg.bit_ticks = BIT_TICKS_RESET;
    rx_cfg.timeout_samples = TIMEOUT_SAMPLES_RESET;
    start_fresh_search();
    rx_bit_timer = '0;
    rx_bit_index = '0;
    rx_shift_bits = '0;
  endtask

  // Advances the receiver model by one line sample and queues any result it causes.
  task automatic advance_receiver(input logic lvl);
    logic [TickWidth:0] next_timer;
    logic rising;
    logic falling;
    logic synced;
    int diff;
    if (rx_receiving) begin
      next_timer = {1'b0, rx_bit_timer} + 1'b1;
      if (next_timer >= {1'b0, rx_cfg.bit_ticks}) begin
        rx_bit_timer = '0;
        rx_shift_bits = {rx_shift_bits[ByteWidth-2:0], lvl};
        if (rx_bit_index == LAST_BIT) begin
          rx_expected_q.push_back('{kind: KIND_DATA, data: rx_shift_bits});
          start_fresh_search();
          rx_bit_index = '0;
          rx_shift_bits = '0;
        end else begin
          rx_bit_index = rx_bit_index + 1'b1;
        end
      end else begin
        rx_bit_timer = next_timer[TickWidth-1:0];
      end
    end else begin
      rising = rx_prev_valid && !rx_prev_level && lvl;
      falling = rx_prev_valid && rx_prev_level && !lvl;
      if (rising) begin
        rx_rise_seen = 1'b1;
        rx_pulse_count = '0;
      end else if (rx_pulse_count != PULSE_MAX) begin
        rx_pulse_count = rx_pulse_count + 1'b1;
      end
      rx_prev_level = lvl;
      rx_prev_valid = 1'b1;
      synced = 1'b0;
      if (falling && rx_rise_seen) begin
        diff = int'(rx_pulse_count) - int'(rx_cfg.sync_ticks);
        if (diff < 0) diff = -diff;
        if (diff < int'(rx_cfg.sync_margin)) begin
          rx_receiving = 1'b1;
          rx_bit_timer = '0;
          rx_bit_index = '0;
          rx_shift_bits = '0;
          synced = 1'b1;
        end
      end
      // The sync tick itself is not counted as a search sample.
      if (!synced) begin
        rx_search_count = rx_search_count + 1'b1;
        if (rx_search_count >= rx_cfg.timeout_samples) begin
          rx_expected_q.push_back('{kind: KIND_TIMEOUT, data: '0});
          start_fresh_search();
        end
      end
    end
  endtask

  task automatic send_sample(input logic lvl);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    line_level <= lvl;
    do begin
      @(negedge clk);
      took = !sample_stall;
      @(posedge clk);
    end while (!took);
    sample_count++;
    advance_receiver(lvl);
  endtask

  // Stops the sender and waits until every queued result has come out.
  task automatic settle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (rx_expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_index_t idx, input logic [CfgDataWidth-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_SYNC_TICKS:      rx_cfg.sync_ticks = val[TickWidth-1:0];
      CFG_SYNC_MARGIN:     rx_cfg.sync_margin = val[TickWidth-1:0];
      CFG_BIT_TICKS:       rx_cfg.bit_ticks = val[TickWidth-1:0];
      CFG_TIMEOUT_SAMPLES: rx_cfg.timeout_samples = val;
      default: ;
    endcase
  endtask

  // Upper bits of the 12-bit registers get random junk that must be dropped.
  task automatic configure(input int st, input int mg, input int bt, input int tmo);
    settle();
    cfg_write <= 1'b1;
    put_reg(CFG_SYNC_TICKS, {4'($urandom), 12'(st)});
    put_reg(CFG_SYNC_MARGIN, {4'($urandom), 12'(mg)});
    put_reg(CFG_BIT_TICKS, {4'($urandom), 12'(bt)});
    put_reg(CFG_TIMEOUT_SAMPLES, 16'(tmo));
    cfg_write <= 1'b0;
  endtask

  // Low lead-in, high pulse, falling tick, then nbits data bits held for one bit period.
  task automatic send_frame(input int lead, input int high_w, input logic [7:0] bits,
                            input int nbits);
    int bt;
    bt = (rx_cfg.bit_ticks == '0) ? 1 : int'(rx_cfg.bit_ticks);
    repeat (lead) send_sample(1'b0);
    repeat (high_w) send_sample(1'b1);
    send_sample(1'b0);
    for (int i = 7; i >= 8 - nbits; i--) begin
      repeat (bt) send_sample(bits[i]);
    end
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_sample(1'($urandom));
  endtask

  task automatic send_random_frame(input int nbits);
    int mg;
    int off;
    int w;
    mg = int'(rx_cfg.sync_margin);
    if (mg > 0 && $urandom_range(99) < 80) begin
      off = int'($urandom_range(2 * mg - 2)) - (mg - 1);
    end else begin
      off = mg + int'($urandom_range(3));
      if ($urandom_range(1) == 0) off = -off;
    end
    w = int'(rx_cfg.sync_ticks) + off;
    if (w < 1) w = 1;
    send_frame($urandom_range(4, 1), w, 8'($urandom), nbits);
  endtask

  task automatic pick_random_settings();
    int st;
    int mg;
    int bt;
    int tmo;
    st = $urandom_range(24, 1);
    mg = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
    bt = ($urandom_range(15) == 0) ? 0 : $urandom_range(5, 1);
    tmo = ($urandom_range(5) == 0) ? $urandom_range(20, 3) : $urandom_range(300, st + 40);
    configure(st, mg, bt, tmo);
  endtask

  task automatic test_reset_values();
    send_idle_pct = 10;
    recv_idle_pct = 30;
    send_frame(2, 150, 8'hA5, 8);
  endtask

  task automatic test_margin_edges();
    configure(8, 3, 1, 200);
    send_frame(2, 10, 8'hFF, 8);
    send_frame(1, 6, 8'h00, 8);
    send_frame(3, 11, 8'h80, 8);
    send_frame(2, 5, 8'h01, 8);
    send_frame(2, 8, 8'h7E, 8);
  endtask

  task automatic test_fall_without_rise();
    configure(4, 2, 1, 100);
    send_frame(1, 4, 8'h55, 8);
    // The search restarts here, so the first high sample is not a rising edge.
    send_sample(1'b1);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b0);
    send_frame(1, 4, 8'h3C, 8);
  endtask

  task automatic test_zero_margin();
    configure(5, 0, 2, 30);
    send_frame(2, 5, 8'hAA, 8);
    repeat (10) send_sample(1'b0);
  endtask

  task automatic test_timeout_extremes();
    configure(4, 2, 1, 1);
    repeat (3) send_sample(1'b0);
    configure(4, 2, 1, 0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b1);
    configure(4, 2, 0, 100);
    send_frame(2, 4, 8'hC3, 8);
  endtask

  task automatic test_register_extremes();
    configure(4095, 4095, 2, 65535);
    send_frame(1, 2, 8'h5A, 8);
    configure(1, 1, 1, 65535);
    send_frame(1, 1, 8'h01, 8);
  endtask

  task automatic test_random_traffic(input int s_pct, input int r_pct, input int target);
    int sent0;
    int pick;
    int burst;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent0 = sample_count;
    while (sample_count - sent0 < target) begin
      pick_random_settings();
      burst = $urandom_range(8, 3);
      while (burst > 0 && sample_count - sent0 < target) begin
        pick = $urandom_range(99);
        if (pick < 75) send_random_frame(8);
        else if (pick < 90) send_noise($urandom_range(40, 5));
        else send_random_frame($urandom_range(7));
        burst--;
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    sample_valid <= 1'b0;
    line_level <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_SYNC_TICKS;
    cfg_data <= '0;
    reset_receiver_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_margin_edges();
    test_fall_without_rise();
    test_zero_margin();
    test_timeout_extremes();
    test_register_extremes();
    test_random_traffic(27, 82, 180);
    test_random_traffic(82, 27, 180);
    test_random_traffic(0, 0, 180);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    settle();
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
